/* hdl/lmpsm_pkg.sv */
// lmpsm_pkg: shared types and defaults for the leveled multi-pattern substring matcher
// used by the front queue, the match engine and the top level
`timescale 1ns / 1ps
`default_nettype none
package lmpsm_pkg;

    localparam int MAX_WORDS_DEF = 64;
    localparam int WORD_LEN_DEF  = 32;
    localparam int MAX_INPUT_DEF = 256;

    typedef enum logic [1:0] {
        CMD_PBYTE = 2'd0,
        CMD_PHDR  = 2'd1,
        CMD_TEXT  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [5:0]        entry;
        logic [4:0]        offset;
        logic [7:0]        data;
        logic [4:0]        length;
        logic signed [7:0] level;
        logic              last;
    } item_t;

    // handoff between the queue and the engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage
`default_nettype wire

/* hdl/leveled_multi_pattern_substring_match.sv */
// leveled_multi_pattern_substring_match: top level, configuration register and wiring
// depends on lmpsm_pkg, lmpsm_front and lmpsm_back
`timescale 1ns / 1ps
`default_nettype none
// Pattern table loads and text bytes enter through a two-entry queue and are
// worked one at a time by a sequencer over three memories (pattern bytes,
// headers, first-start positions). A table write completes in the idle state.
// A text byte is shifted into the window; then, for each of the MAX_WORDS
// entries, the header is read and checked and the pattern bytes are read and
// compared one by one until a mismatch or a full match.
// A zero byte or a byte past the input cap skips the compare loop. The byte
// marked last adds a report scan over up to min(word_count, MAX_WORDS) entries,
// plus any wait of the result on result_stall. The compare loop runs over the
// single read port of the pattern byte memory.
// No clearing pass follows reset.
module leveled_multi_pattern_substring_match #(
    parameter int MAX_WORDS = lmpsm_pkg::MAX_WORDS_DEF,
    parameter int WORD_LEN  = lmpsm_pkg::WORD_LEN_DEF,
    parameter int MAX_INPUT = lmpsm_pkg::MAX_INPUT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  command,
    input  wire logic [5:0]  entry,
    input  wire logic [4:0]  offset,
    input  wire logic [7:0]  data,
    input  wire logic [4:0]  length,
    input  wire logic signed [7:0] level,
    input  wire logic        last,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             matched,
    output logic [5:0]       pattern_index,
    output logic [7:0]       match_start,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);
    import lmpsm_pkg::*;

    item_t       item_in;
    queue_head_t head;
    logic        pop;
    logic [6:0]  wc_reg;

    assign item_in.cmd    = cmd_t'(command);
    assign item_in.entry  = entry;
    assign item_in.offset = offset;
    assign item_in.data   = data;
    assign item_in.length = length;
    assign item_in.level  = level;
    assign item_in.last   = last;
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg <= 7'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wc_reg <= cfg_data;
        end
    end

    lmpsm_front u_front (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_stall(item_stall),
        .item_in(item_in), .head(head), .pop(pop)
    );

    lmpsm_back #(.MAX_WORDS(MAX_WORDS), .WORD_LEN(WORD_LEN), .MAX_INPUT(MAX_INPUT)) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .word_count(wc_reg),
        .result_valid(result_valid), .result_stall(result_stall), .matched(matched),
        .pattern_index(pattern_index), .match_start(match_start)
    );
endmodule
`default_nettype wire

/* hdl/lmpsm_ram.sv */
// lmpsm_ram: generic single write port, single registered read port memory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lmpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

/* hdl/lmpsm_front.sv */
// lmpsm_front: input acceptance, text lowercasing and a two-entry queue
// depends on lmpsm_pkg
`timescale 1ns / 1ps
`default_nettype none
module lmpsm_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire lmpsm_pkg::item_t     item_in,
    output lmpsm_pkg::queue_head_t    head,
    input  wire logic                 pop
);
    import lmpsm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      cls;

    always_comb
    begin
        cls = item_in;
        if (item_in.cmd == CMD_TEXT && item_in.data >= 8'h41 && item_in.data <= 8'h5a)
        begin
            cls.data = item_in.data + 8'h20;
        end
    end

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/lmpsm_back.sv */
// lmpsm_back: table writes, per-byte pattern comparison and end-of-string report
// depends on lmpsm_pkg and lmpsm_ram
`timescale 1ns / 1ps
`default_nettype none
module lmpsm_back #(
    parameter int MAX_WORDS = lmpsm_pkg::MAX_WORDS_DEF,
    parameter int WORD_LEN  = lmpsm_pkg::WORD_LEN_DEF,
    parameter int MAX_INPUT = lmpsm_pkg::MAX_INPUT_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lmpsm_pkg::queue_head_t head,
    output logic                        pop,
    input  wire logic [6:0]             word_count,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic                        matched,
    output logic [5:0]                  pattern_index,
    output logic [7:0]                  match_start
);
    import lmpsm_pkg::*;

    localparam int EW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int EWP  = $clog2(MAX_WORDS + 1);
    localparam int NW   = (EWP > 7) ? EWP : 7;
    localparam int LW   = $clog2(WORD_LEN);
    localparam int SLOT = WORD_LEN - 1;
    localparam int SW   = $clog2(MAX_INPUT);
    localparam int BDEP = MAX_WORDS * (2 ** LW);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_TAKE = 12'b000000000010,
        S_MHDR = 12'b000000000100,
        S_MHCK = 12'b000000001000,
        S_MBRD = 12'b000000010000,
        S_MBCK = 12'b000000100000,
        S_END  = 12'b000001000000,
        S_SHDR = 12'b000010000000,
        S_SHCK = 12'b000100000000,
        S_FRD  = 12'b001000000000,
        S_FCK  = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    state_t           state_reg, state_next;
    item_t            cur_reg, cur_next;
    logic [7:0]       win_reg [SLOT];
    logic [7:0]       win_next [SLOT];
    logic [SW-1:0]    seen_reg, seen_next;
    logic [MAX_WORDS-1:0] found_reg, found_next;
    logic [EWP-1:0]   e_reg, e_next;
    logic [LW-1:0]    j_reg, j_next;
    logic [LW-1:0]    len_reg, len_next;
    logic             rv_reg, rv_next;
    logic             rm_reg, rm_next;
    logic [5:0]       ri_reg, ri_next;
    logic [7:0]       rs_reg, rs_next;
    logic             hit_reg, hit_next;
    logic [5:0]       hi_reg, hi_next;
    logic [7:0]       hs_reg, hs_next;

    // memory ports
    logic                  b_we, h_we, f_we;
    logic [EW+LW-1:0]      b_waddr, b_raddr;
    logic [7:0]            b_rdata;
    logic [EW-1:0]         h_waddr, f_waddr;
    logic [LW+7:0]         h_wdata, h_rdata;
    logic [SW-1:0]         f_wdata, f_rdata;
    logic [LW-1:0]         h_len;
    logic signed [7:0]     h_lvl;
    logic [EW-1:0]         e_idx;
    logic [NW-1:0]         n_words, wc_ext, e_ext;
    logic [LW-1:0]         win_idx;
    logic                  entry_ok;

    assign e_idx   = e_reg[EW-1:0];
    assign h_len   = h_rdata[LW+7:8];
    assign h_lvl   = h_rdata[7:0];
    assign wc_ext  = NW'(word_count);
    assign n_words = (int'(wc_ext) > MAX_WORDS) ? NW'(MAX_WORDS) : wc_ext;
    assign e_ext   = NW'(e_reg);
    assign win_idx = len_reg - 1'b1 - j_reg;
    assign entry_ok = int'(head.item.entry) < MAX_WORDS;

    assign b_we    = (state_reg == S_IDLE) && head.valid && head.item.cmd == CMD_PBYTE
                     && entry_ok && int'(head.item.offset) < SLOT;
    assign b_waddr = {EW'(head.item.entry), LW'(head.item.offset)};
    assign b_raddr = {e_idx, j_reg};
    assign h_we    = (state_reg == S_IDLE) && head.valid && head.item.cmd == CMD_PHDR
                     && entry_ok;
    assign h_waddr = EW'(head.item.entry);
    assign h_wdata = {(int'(head.item.length) > SLOT) ? LW'(SLOT) : LW'(head.item.length),
                      head.item.level};
    assign f_we    = (state_reg == S_MBCK) && (b_rdata == win_reg[win_idx])
                     && (j_reg == len_reg - 1'b1);
    assign f_waddr = e_idx;
    assign f_wdata = SW'(int'(seen_reg) - int'(len_reg));

    lmpsm_ram #(.WIDTH(8), .DEPTH(BDEP)) u_bytes (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(head.item.data),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    lmpsm_ram #(.WIDTH(LW + 8), .DEPTH(MAX_WORDS)) u_hdr (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(e_idx), .rdata(h_rdata)
    );

    lmpsm_ram #(.WIDTH(SW), .DEPTH(MAX_WORDS)) u_first (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(e_idx), .rdata(f_rdata)
    );

    assign pop           = (state_reg == S_IDLE) && head.valid;
    assign result_valid  = rv_reg;
    assign matched       = rm_reg;
    assign pattern_index = ri_reg;
    assign match_start   = rs_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        win_next   = win_reg;
        seen_next  = seen_reg;
        found_next = found_reg;
        e_next     = e_reg;
        j_next     = j_reg;
        len_next   = len_reg;
        rv_next    = rv_reg && result_stall;
        rm_next    = rm_reg;
        ri_next    = ri_reg;
        rs_next    = rs_reg;
        hit_next   = hit_reg;
        hi_next    = hi_reg;
        hs_next    = hs_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    cur_next = head.item;
                    if (head.item.cmd == CMD_TEXT)
                    begin
                        state_next = S_TAKE;
                    end
                end
            end
            S_TAKE:
            begin
                if (int'(seen_reg) >= MAX_INPUT - 1)
                begin
                    state_next = S_END;
                end
                else if (cur_reg.data == 8'd0)
                begin
                    seen_next  = SW'(MAX_INPUT - 1);
                    state_next = S_END;
                end
                else
                begin
                    for (int k = SLOT - 1; k > 0; k--)
                    begin
                        win_next[k] = win_reg[k - 1];
                    end
                    win_next[0] = cur_reg.data;
                    seen_next   = seen_reg + 1'b1;
                    e_next      = '0;
                    state_next  = S_MHDR;
                end
            end
            S_MHDR:
            begin
                state_next = S_MHCK;
            end
            S_MHCK:
            begin
                len_next = h_len;
                j_next   = '0;
                if (found_reg[e_idx] || h_len == '0 || int'(seen_reg) < int'(h_len))
                begin
                    if (int'(e_reg) == MAX_WORDS - 1)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = S_MHDR;
                    end
                end
                else
                begin
                    state_next = S_MBRD;
                end
            end
            S_MBRD:
            begin
                state_next = S_MBCK;
            end
            S_MBCK:
            begin
                if (b_rdata == win_reg[win_idx] && j_reg != len_reg - 1'b1)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MBRD;
                end
                else
                begin
                    if (f_we)
                    begin
                        found_next[e_idx] = 1'b1;
                    end
                    if (int'(e_reg) == MAX_WORDS - 1)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = S_MHDR;
                    end
                end
            end
            S_END:
            begin
                e_next     = '0;
                hit_next   = 1'b0;
                hi_next    = '0;
                hs_next    = '0;
                state_next = cur_reg.last ? S_SHDR : S_IDLE;
            end
            S_SHDR:
            begin
                state_next = (e_ext >= n_words) ? S_OUT : S_SHCK;
            end
            S_SHCK:
            begin
                if (cur_reg.level < h_lvl)
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_SHDR;
                end
                else if (h_len == '0)
                begin
                    hit_next   = 1'b1;
                    hi_next    = 6'(e_reg);
                    state_next = S_OUT;
                end
                else if (found_reg[e_idx])
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_SHDR;
                end
            end
            S_FRD:
            begin
                state_next = S_FCK;
            end
            S_FCK:
            begin
                hit_next   = 1'b1;
                hi_next    = 6'(e_reg);
                hs_next    = 8'(f_rdata);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to drain before the next transfer
                if (!rv_reg || !result_stall)
                begin
                    rv_next    = 1'b1;
                    rm_next    = hit_reg;
                    ri_next    = hi_reg;
                    rs_next    = hs_reg;
                    seen_next  = '0;
                    found_next = '0;
                    for (int k = 0; k < SLOT; k++)
                    begin
                        win_next[k] = 8'd0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        e_reg   <= e_next;
        j_reg   <= j_next;
        len_reg <= len_next;
        rm_reg  <= rm_next;
        ri_reg  <= ri_next;
        rs_reg  <= rs_next;
        hit_reg <= hit_next;
        hi_reg  <= hi_next;
        hs_reg  <= hs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= '0;
            found_reg <= '0;
            rv_reg    <= 1'b0;
            for (int k = 0; k < SLOT; k++)
            begin
                win_reg[k] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            found_reg <= found_next;
            rv_reg    <= rv_next;
            win_reg   <= win_next;
        end
    end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for the leveled multi-pattern substring matcher
// depends on lmpsm_pkg and leveled_multi_pattern_substring_match; table loads and
// text strings go in, each reported result is checked against an in-bench predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import lmpsm_pkg::*;

    localparam int SLOT = 31;

    typedef struct {
        bit       hit;
        bit [5:0] idx;
        bit [7:0] start;
    } match_t;

    typedef struct {
        item_t  it;
        bit     typed;
        match_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  command;
    logic [5:0]  entry;
    logic [4:0]  offset;
    logic [7:0]  data;
    logic [4:0]  length;
    logic signed [7:0] level;
    logic        last;
    logic        result_valid;
    logic        result_stall;
    logic        matched;
    logic [5:0]  pattern_index;
    logic [7:0]  match_start;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    leveled_multi_pattern_substring_match u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .command(command), .entry(entry), .offset(offset), .data(data),
        .length(length), .level(level), .last(last),
        .result_valid(result_valid), .result_stall(result_stall),
        .matched(matched), .pattern_index(pattern_index), .match_start(match_start),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // mirror of the pattern table and the per-string match state
    bit [7:0] pat_byte [64][SLOT];
    int       pat_len  [64];
    int       pat_lvl  [64];
    int       wr_prefix[64];
    bit [7:0] window   [SLOT];
    int       seen;
    bit       found    [64];
    int       first_at [64];
    int       active_words;

    match_t   pending_matches[$];
    int       mismatches;
    bit       failed;
    bit       gaps_on;
    bit       hold_req;
    int       n_items;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_string_state();
        for (int k = 0; k < SLOT; k++) window[k] = 8'h00;
        for (int e = 0; e < 64; e++)
        begin
            found[e] = 1'b0;
            first_at[e] = 0;
        end
        seen = 0;
    endfunction

    function automatic void scan_text_byte(bit [7:0] c);
        bit hit;
        if (seen >= 255) return;
        if (c == 8'h00)
        begin
            seen = 255;
            return;
        end
        if (c >= "A" && c <= "Z") c = c + 8'h20;
        for (int k = SLOT - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = c;
        seen++;
        for (int e = 0; e < 64; e++)
        begin
            if (found[e] || pat_len[e] == 0 || seen < pat_len[e]) continue;
            hit = 1'b1;
            for (int j = 0; j < pat_len[e]; j++)
                if (pat_byte[e][j] != window[pat_len[e]-1-j]) hit = 1'b0;
            if (hit)
            begin
                found[e] = 1'b1;
                first_at[e] = seen - pat_len[e];
            end
        end
    endfunction

    // returns 1 when the item produces a result report
    function automatic bit predict_match(item_t it, output match_t r);
        int n;
        r = '{0, 0, 0};
        case (it.cmd)
            CMD_PBYTE: if (it.offset < SLOT) pat_byte[it.entry][it.offset] = it.data;
            CMD_PHDR:
            begin
                pat_len[it.entry] = (it.length > SLOT) ? SLOT : it.length;
                pat_lvl[it.entry] = it.level;
            end
            CMD_TEXT:
            begin
                scan_text_byte(it.data);
                if (it.last)
                begin
                    n = (active_words > 64) ? 64 : active_words;
                    for (int e = 0; e < n; e++)
                    begin
                        if (int'(it.level) < pat_lvl[e]) continue;
                        if (pat_len[e] == 0 || found[e])
                        begin
                            r.hit = 1'b1;
                            r.idx = 6'(e);
                            r.start = (pat_len[e] == 0) ? 8'd0 : first_at[e][7:0];
                            break;
                        end
                    end
                    clear_string_state();
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic item_t mk(cmd_t c, int e, int off, int d, int len, int lvl, int lst);
        item_t it;
        it.cmd = c;
        it.entry = 6'(e);
        it.offset = 5'(off);
        it.data = 8'(d);
        it.length = 5'(len);
        it.level = 8'(lvl);
        it.last = lst[0];
        return it;
    endfunction

    // drive one item and hold it until the transfer; typed rows override the prediction
    task automatic send(item_t it, bit typed = 1'b0, match_t want = '{0, 0, 0});
        bit taken;
        bit gives;
        match_t r;
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        command <= it.cmd;
        entry <= it.entry;
        offset <= it.offset;
        data <= it.data;
        length <= it.length;
        level <= it.level;
        last <= it.last;
        do
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end while (!taken);
        gives = predict_match(it, r);
        if (gives) pending_matches.push_back(typed ? want : r);
        n_items++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_word_count(int v);
        cfg_valid <= 1'b1;
        cfg_data <= 7'(v);
        do
        begin
            @(negedge clk);
        end while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        active_words = v;
    endtask

    function automatic bit [7:0] text_char();
        int p;
        string s;
        s = "abcABC";
        p = $urandom_range(0, 99);
        if (p < 70) return s[$urandom_range(0, 5)];
        if (p < 80) return 8'("a" + $urandom_range(0, 25));
        if (p < 97) return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    function automatic bit [7:0] pattern_char();
        string s;
        s = "abc";
        if ($urandom_range(0, 9) < 8) return s[$urandom_range(0, 2)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_string(int n);
        int lvl;
        lvl = $urandom_range(0, 255);
        for (int i = 0; i < n; i++)
            send(mk(CMD_TEXT, $urandom_range(0, 63), $urandom_range(0, 31), text_char(),
                    $urandom_range(0, 31), lvl, i == n - 1));
    endtask

    task automatic random_phase(int count);
        int p;
        int e;
        int off;
        int stop;
        stop = n_items + count;
        while (n_items < stop)
        begin
            p = $urandom_range(0, 99);
            e = $urandom_range(0, 63);
            if (p < 72)
                send_string(($urandom_range(0, 99) < 2) ? $urandom_range(260, 300)
                                                         : $urandom_range(1, 10));
            else if (p < 84)
            begin
                off = (wr_prefix[e] < SLOT && $urandom_range(0, 9) < 7) ? wr_prefix[e]
                                                                       : $urandom_range(0, 31);
                if (off == wr_prefix[e] && off < SLOT) wr_prefix[e]++;
                send(mk(CMD_PBYTE, e, off, pattern_char(), $urandom_range(0, 31),
                        $urandom_range(0, 255), $urandom_range(0, 1)));
            end
            else if (p < 93)
                send(mk(CMD_PHDR, e, $urandom_range(0, 31), $urandom_range(0, 255),
                        $urandom_range(0, wr_prefix[e]), $urandom_range(0, 255),
                        $urandom_range(0, 1)));
            else if (p < 96)
                send(mk(CMD_NONE, e, $urandom_range(0, 31), $urandom_range(0, 255),
                        $urandom_range(0, 31), $urandom_range(0, 255), $urandom_range(0, 1)));
            else
                // broken string: bytes with no last, folded into the next string
                send(mk(CMD_TEXT, e, 0, text_char(), 0, $urandom_range(0, 255), 0));
        end
        send_string($urandom_range(1, 6));
    endtask

    // result side: random stall per transfer, one long hold on request
    initial
    begin
        match_t want;
        int w;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(posedge clk);
                result_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (result_valid && !result_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: hit=%0d idx=%0d start=%0d",
                                 matched, pattern_index, match_start);
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (matched !== want.hit || pattern_index !== want.idx
                        || match_start !== want.start)
                    begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("match mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.hit, want.idx, want.start,
                                     matched, pattern_index, match_start);
                    end
                end
                @(posedge clk);
                w = gaps_on ? $urandom_range(0, 11) : 0;
                if (w > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        int len;
        rst_n = 1'b0;
        item_valid = 1'b0;
        command = CMD_NONE;
        entry = '0;
        offset = '0;
        data = '0;
        length = '0;
        level = '0;
        last = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        failed = 1'b0;
        mismatches = 0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        n_items = 0;
        active_words = 0;
        for (int e = 0; e < 64; e++)
        begin
            pat_len[e] = 0;
            pat_lvl[e] = 0;
            wr_prefix[e] = 0;
            for (int j = 0; j < SLOT; j++) pat_byte[e][j] = 8'h00;
        end
        clear_string_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry gets a header before any text; entry 63 gets a full-length pattern
        for (int e = 0; e < 64; e++)
        begin
            len = (e == 63) ? SLOT : $urandom_range(0, 4);
            for (int j = 0; j < len; j++)
                send(mk(CMD_PBYTE, e, j, (e == 63) ? "a" : pattern_char(), 0, 0, 1'b0));
            wr_prefix[e] = len;
            send(mk(CMD_PHDR, e, 0, 0, len, $urandom_range(0, 255), 1'b0));
        end
        // word_count still at reset: nothing takes part
        send(mk(CMD_TEXT, 0, 0, "a", 0, 127, 1'b1), 1'b1, '{0, 0, 0});
        drain();
        write_word_count(64);

        rows.push_back('{mk(CMD_PHDR, 0, 0, 0, 0, -128, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 63, 31, "X", 31, 127, 1), 1, '{1, 0, 0}});
        rows.push_back('{mk(CMD_PHDR, 0, 0, 0, 0, 127, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_PBYTE, 1, 0, "a", 0, 0, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_PBYTE, 1, 1, "b", 0, 0, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_PHDR, 1, 0, 0, 2, -128, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, "Q", 0, -128, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, "A", 0, -128, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, "B", 0, -128, 1), 1, '{1, 1, 1}});
        // offset past the slot is dropped, unused command does nothing
        rows.push_back('{mk(CMD_PBYTE, 1, 31, 8'hff, 0, 0, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_NONE, 63, 31, 8'hff, 31, -1, 1), 0, '{0, 0, 0}});
        // zero byte ends the content, the later b is ignored
        rows.push_back('{mk(CMD_TEXT, 0, 0, "a", 0, -128, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, 8'h00, 0, -128, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, "b", 0, -128, 1), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_PHDR, 63, 0, 0, 31, 0, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_PBYTE, 2, 30, 8'hff, 0, 0, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, 8'hff, 0, 127, 0), 0, '{0, 0, 0}});
        rows.push_back('{mk(CMD_TEXT, 0, 0, 8'h80, 0, 127, 1), 0, '{0, 0, 0}});
        foreach (rows[i])
        begin
            rw = rows[i];
            send(rw.it, rw.typed, rw.want);
        end
        drain();

        // long run of a's reaches the full-length pattern and the input cap
        gaps_on = 1'b0;
        send_string(0);
        for (int i = 0; i < 280; i++)
            send(mk(CMD_TEXT, 0, 0, "A", 0, 127, i == 279));
        drain();

        gaps_on = 1'b1;
        hold_req = 1'b1;
        random_phase(40);
        drain();
        write_word_count(127);
        gaps_on = 1'b0;
        random_phase(40);
        drain();
        write_word_count(1);
        gaps_on = 1'b1;
        random_phase(30);
        drain();
        write_word_count($urandom_range(2, 63));
        random_phase(40);
        drain();
        write_word_count(0);
        random_phase(20);
        drain();
        write_word_count(64);
        random_phase(40);
        drain();

        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
